// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on the rising edge, masked during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/stu_pkg.sv =====
package stu_pkg;

  localparam int MAX_LEXEME_DEF  = 4096;
  localparam int LINE_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 24;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

  localparam logic [4:0] KIND_END         = 5'd0;
  localparam logic [4:0] KIND_IDENT       = 5'd1;
  localparam logic [4:0] KIND_NUMBER      = 5'd2;
  localparam logic [4:0] KIND_STRING      = 5'd3;
  localparam logic [4:0] KIND_IF          = 5'd4;
  localparam logic [4:0] KIND_DO          = 5'd5;
  localparam logic [4:0] KIND_FOR         = 5'd6;
  localparam logic [4:0] KIND_KW_END      = 5'd7;
  localparam logic [4:0] KIND_ELSE        = 5'd8;
  localparam logic [4:0] KIND_WHILE       = 5'd9;
  localparam logic [4:0] KIND_COMMA       = 5'd10;
  localparam logic [4:0] KIND_LPAREN      = 5'd11;
  localparam logic [4:0] KIND_RPAREN      = 5'd12;
  localparam logic [4:0] KIND_SEMI        = 5'd13;
  localparam logic [4:0] KIND_PLUS        = 5'd14;
  localparam logic [4:0] KIND_MINUS       = 5'd15;
  localparam logic [4:0] KIND_STAR        = 5'd16;
  localparam logic [4:0] KIND_SLASH       = 5'd17;
  localparam logic [4:0] KIND_ASSIGN      = 5'd18;
  localparam logic [4:0] KIND_BANG        = 5'd19;
  localparam logic [4:0] KIND_PIPE        = 5'd20;
  localparam logic [4:0] KIND_LBRACE      = 5'd21;
  localparam logic [4:0] KIND_RBRACE      = 5'd22;
  localparam logic [4:0] KIND_LBRACKET    = 5'd23;
  localparam logic [4:0] KIND_RBRACKET    = 5'd24;
  localparam logic [4:0] KIND_ERROR       = 5'd25;
  localparam logic [4:0] KIND_PUNCT_FIRST = KIND_COMMA;
  localparam logic [4:0] KIND_PUNCT_LAST  = KIND_RBRACKET;

  typedef struct packed {
    logic [4:0]  kind;
    logic [11:0] len;
    logic [23:0] start;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } result_t;

  // results of one byte; vld1 only ever set together with vld0
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return b inside {["0":"9"], ["a":"z"], ["A":"Z"], "_", "."};
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    return b inside {8'h0A, 8'h0D};
  endfunction

  // KIND_END when the byte is not punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      ",":     k = KIND_COMMA;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ";":     k = KIND_SEMI;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "=":     k = KIND_ASSIGN;
      "!":     k = KIND_BANG;
      "|":     k = KIND_PIPE;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // prefix holds the first word byte lowest, hence the reversed literals
  function automatic logic [4:0] keyword_kind(input logic [31:0] len, input logic [63:0] kw);
    logic [4:0] k;
    k = KIND_IDENT;
    if      (len == 32'd2 && kw == 64'("fi"))       k = KIND_IF;
    else if (len == 32'd2 && kw == 64'("od"))       k = KIND_DO;
    else if (len == 32'd3 && kw == 64'("rof"))      k = KIND_FOR;
    else if (len == 32'd3 && kw == 64'("dne"))      k = KIND_KW_END;
    else if (len == 32'd4 && kw == 64'("esle"))     k = KIND_ELSE;
    else if (len == 32'd5 && kw == 64'("elihw"))    k = KIND_WHILE;
    else if (len == 32'd5 && kw == 64'("kaerb"))    k = KIND_WHILE;
    else if (len == 32'd8 && kw == 64'("eunitnoc")) k = KIND_WHILE;
    return k;
  endfunction

endpackage

// ===== hw/rtl/script_tokenizer_unit.sv =====
// Path: an accepted byte is registered at the input; its results enter the result queue.
// Throughput: one byte per cycle while the result queue has room for two results; a
// byte that yields two results (word end plus a punctuation or end token, string error
// plus end) fills the four-entry queue faster than the single-beat port drains it.
// Reset: rst_n low (synchronous) returns to the start of a text, line and column 1.
module script_tokenizer_unit #(
  parameter int MAX_LEXEME  = stu_pkg::MAX_LEXEME_DEF,
  parameter int LINE_BITS   = stu_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = stu_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [11:0] out_lexeme_length,
  output logic [23:0] out_start_offset,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic        out_last_of_run
);
  import stu_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       take, room2, not_empty;
  push_t      push;
  result_t    head;

  assign take     = in_vld_r & room2;
  assign in_ready = !in_vld_r | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_src_byte;
  end

  stu_core #(
    .MAX_LEXEME  (MAX_LEXEME),
    .LINE_BITS   (LINE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .src_byte (in_byte_r),
    .push     (push)
  );

  stu_result_fifo u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_valid & out_ready),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_valid         = not_empty;
  assign out_token_kind    = head.kind;
  assign out_lexeme_length = head.len;
  assign out_start_offset  = head.start;
  assign out_line_number   = head.line;
  assign out_column_number = head.col;
  assign out_last_of_run   = head.last;

endmodule

// ===== hw/rtl/stu_core.sv =====
module stu_core #(
  parameter int MAX_LEXEME  = stu_pkg::MAX_LEXEME_DEF,
  parameter int LINE_BITS   = stu_pkg::LINE_BITS_DEF,
  parameter int OFFSET_BITS = stu_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    src_byte,
  output stu_pkg::push_t push
);
  import stu_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEXEME);
  localparam logic [LEN_W-1:0]     LEN_LIMIT  = LEN_W'(MAX_LEXEME - 1);
  localparam logic [LINE_BITS-1:0] LINE_LIMIT = '1;

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_WORD    = 5'b00010,
    M_STR     = 5'b00100,
    M_STR_ESC = 5'b01000,
    M_COMMENT = 5'b10000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic                   dq_r, dq_nxt;
  logic                   num_r, num_nxt;
  logic [63:0]            kw_r, kw_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [15:0]            col_r, col_nxt;

  logic [LEN_W:0]         sum1, sum2;
  logic [LEN_W-1:0]       len_p1, len_p2, len_s, len_s_p1;
  logic [OFFSET_BITS-1:0] pos_upd;
  logic [LINE_BITS-1:0]   line_upd;
  logic [15:0]            col_upd, col_str;
  logic [31:0]            cu32, ls32, cdiff;
  logic                   eol, quote_b, match_q;
  logic [4:0]             pk;

  function automatic result_t mk(input logic [4:0] k, input logic [LEN_W-1:0] l,
                                 input logic [OFFSET_BITS-1:0] s,
                                 input logic [LINE_BITS-1:0] n, input logic [15:0] c);
    result_t     r;
    logic [31:0] lw, sw, nw;
    lw = 32'(l);
    sw = 32'(s);
    nw = 32'(n);
    r.kind  = k;
    r.len   = lw[11:0];
    r.start = sw[23:0];
    r.line  = nw[15:0];
    r.col   = c;
    r.last  = 1'b0;
    return r;
  endfunction

  assign sum1     = {1'b0, len_r} + (LEN_W+1)'(1);
  assign sum2     = {1'b0, len_r} + (LEN_W+1)'(2);
  assign len_p1   = (sum1 > {1'b0, LEN_LIMIT}) ? LEN_LIMIT : sum1[LEN_W-1:0];
  assign len_p2   = (sum2 > {1'b0, LEN_LIMIT}) ? LEN_LIMIT : sum2[LEN_W-1:0];
  // after a lone backslash the backslash itself counts as content
  assign len_s    = (mode_r == M_STR_ESC) ? len_p1 : len_r;
  assign len_s_p1 = (mode_r == M_STR_ESC) ? len_p2 : len_p1;

  assign eol      = is_eol(src_byte);
  assign quote_b  = (src_byte == "\"") || (src_byte == "'");
  assign match_q  = dq_r ? (src_byte == "\"") : (src_byte == "'");
  assign pk       = punct_kind(src_byte);

  assign pos_upd  = pos_r + OFFSET_BITS'(1);
  assign line_upd = (line_r == LINE_LIMIT) ? line_r : line_r + LINE_BITS'(1);
  assign col_upd  = eol ? 16'd1 : ((col_r == 16'hFFFF) ? col_r : col_r + 16'd1);

  assign cu32     = 32'(col_upd);
  assign ls32     = 32'(len_s);
  assign cdiff    = cu32 - ls32;
  assign col_str  = (cu32 > ls32) ? cdiff[15:0] : 16'd1;

  always_comb begin
    result_t r0, r1, ires;
    logic    v0, v1, iv, do_idle, restart;
    mode_nxt  = mode_r;
    dq_nxt    = dq_r;
    num_nxt   = num_r;
    kw_nxt    = kw_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    r0 = '0;
    r1 = '0;
    ires = '0;
    v0 = 1'b0;
    v1 = 1'b0;
    iv = 1'b0;
    do_idle = 1'b0;
    restart = 1'b0;

    case (mode_r)
      M_WORD: begin
        if (src_byte != 8'd0 && is_word_byte(src_byte)) begin
          if (len_r < LEN_W'(8)) kw_nxt[{len_r[2:0], 3'b000} +: 8] = src_byte;
          len_nxt = len_p1;
          if (!is_digit(src_byte) && src_byte != ".") num_nxt = 1'b0;
          pos_nxt = pos_upd;
          col_nxt = col_upd;
        end else begin
          v0 = 1'b1;
          r0 = mk(num_r ? KIND_NUMBER : keyword_kind(32'(len_r), kw_r),
                  len_r, start_r, line_r, eol ? 16'd1 : col_r);
          do_idle = 1'b1;
        end
      end
      M_STR, M_STR_ESC: begin
        mode_nxt = M_STR;
        if (mode_r == M_STR_ESC && quote_b) begin
          pos_nxt = pos_upd;
          col_nxt = col_upd;
          len_nxt = len_p2;
        end else begin
          len_nxt = len_s;
          if (src_byte == 8'd0) begin
            v0 = 1'b1;
            r0 = mk(KIND_ERROR, len_s, start_r, line_r, col_r);
            v1 = 1'b1;
            r1 = mk(KIND_END, '0, pos_r, line_r, col_r);
            restart = 1'b1;
          end else begin
            pos_nxt = pos_upd;
            col_nxt = col_upd;
            if (eol) begin
              v0 = 1'b1;
              r0 = mk(KIND_ERROR, len_s, start_r, line_r, 16'd1);
              mode_nxt = M_IDLE;
            end else if (src_byte == "\\") begin
              mode_nxt = M_STR_ESC;
            end else if (match_q) begin
              col_nxt = col_str;
              v0 = 1'b1;
              r0 = mk(KIND_STRING, len_s, start_r, line_r, col_str);
              mode_nxt = M_IDLE;
            end else begin
              len_nxt = len_s_p1;
            end
          end
        end
      end
      M_COMMENT: begin
        if (src_byte == 8'd0) begin
          v0 = 1'b1;
          r0 = mk(KIND_END, '0, pos_r, line_r, col_r);
          restart = 1'b1;
        end else begin
          pos_nxt = pos_upd;
          col_nxt = col_upd;
          if (eol) begin
            line_nxt = line_upd;
            mode_nxt = M_IDLE;
          end
        end
      end
      default: do_idle = 1'b1;
    endcase

    // between tokens; also reached by the byte that ends a word
    if (do_idle) begin
      mode_nxt = M_IDLE;
      if (src_byte == 8'd0) begin
        iv = 1'b1;
        ires = mk(KIND_END, '0, pos_r, line_r, col_r);
        restart = 1'b1;
      end else begin
        pos_nxt = pos_upd;
        col_nxt = col_upd;
        if (src_byte == " " || src_byte == 8'h09) begin
          mode_nxt = M_IDLE;
        end else if (eol) begin
          line_nxt = line_upd;
        end else if (src_byte == "#") begin
          mode_nxt = M_COMMENT;
        end else if (quote_b) begin
          mode_nxt  = M_STR;
          dq_nxt    = (src_byte == "\"");
          len_nxt   = '0;
          start_nxt = pos_r;
        end else if (pk != KIND_END) begin
          iv = 1'b1;
          ires = mk(pk, LEN_W'(1), pos_r, line_r, col_upd);
        end else begin
          mode_nxt  = M_WORD;
          len_nxt   = LEN_W'(1);
          start_nxt = pos_r;
          num_nxt   = is_digit(src_byte) || (src_byte == ".");
          kw_nxt    = 64'(src_byte);
        end
      end
      if (iv) begin
        if (v0) begin
          v1 = 1'b1;
          r1 = ires;
        end else begin
          v0 = 1'b1;
          r0 = ires;
        end
      end
    end

    // end token starts a fresh text
    if (restart) begin
      mode_nxt  = M_IDLE;
      dq_nxt    = 1'b0;
      num_nxt   = 1'b1;
      kw_nxt    = '0;
      len_nxt   = '0;
      start_nxt = '0;
      pos_nxt   = '0;
      line_nxt  = LINE_BITS'(1);
      col_nxt   = 16'd1;
    end

    if (v1) r1.last = 1'b1;
    else    r0.last = 1'b1;

    push.vld0 = take & v0;
    push.vld1 = take & v1;
    push.res0 = r0;
    push.res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      dq_r    <= 1'b0;
      num_r   <= 1'b1;
      kw_r    <= '0;
      len_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      line_r  <= LINE_BITS'(1);
      col_r   <= 16'd1;
    end else if (take) begin
      mode_r  <= mode_nxt;
      dq_r    <= dq_nxt;
      num_r   <= num_nxt;
      kw_r    <= kw_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// ===== hw/rtl/stu_result_fifo.sv =====
module stu_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  stu_pkg::push_t   push,
  input  logic             pop,
  output stu_pkg::result_t head,
  output logic             not_empty,
  output logic             room2
);
  import stu_pkg::*;

  result_t             mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [RQ_PTR_W:0]   cnt_r, cnt_nxt;

  assign wr_p1     = wr_r + RQ_PTR_W'(1);
  assign wr_nxt    = wr_r + RQ_PTR_W'(push.vld0) + RQ_PTR_W'(push.vld1);
  assign rd_nxt    = rd_r + RQ_PTR_W'(pop);
  assign cnt_nxt   = cnt_r + (RQ_PTR_W+1)'(push.vld0) + (RQ_PTR_W+1)'(push.vld1)
                     - (RQ_PTR_W+1)'(pop);
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= (RQ_PTR_W+1)'(RQ_DEPTH - 2));
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push.vld0) mem_r[wr_r]  <= push.res0;
    if (push.vld1) mem_r[wr_p1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/stu_checker.sv =====
`include "assert_macros.svh"

module stu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_token_kind,
  input logic [11:0] out_lexeme_length,
  input logic [23:0] out_start_offset,
  input logic [15:0] out_column_number
);
  import stu_pkg::*;

  // stalled beat holds
  `STU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_token_kind) && $stable(out_start_offset), "result beat changed while stalled")

  `STU_ASSERT_IMPLY(a_end_len, clk, rst_n, out_valid && out_token_kind == KIND_END, out_lexeme_length == 12'd0, "end token with nonzero length")

  `STU_ASSERT_IMPLY(a_punct_len, clk, rst_n, out_valid && out_token_kind >= KIND_PUNCT_FIRST && out_token_kind <= KIND_PUNCT_LAST, out_lexeme_length == 12'd1, "punctuation token length not one")

  `STU_ASSERT_IMPLY(a_col_nonzero, clk, rst_n, out_valid, out_column_number != 16'd0, "column number zero")

endmodule

bind script_tokenizer_unit stu_checker u_stu_checker (.*);
